[design/jtdt_pkg.sv]
`default_nettype none

package jtdt_pkg;

    localparam int MAX_TRACKS_DEF  = 256;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CNT_W       = 9;
    localparam int CNT_FIELD_MAX = (2 ** CNT_W) - 1;
    localparam int PT_SUM_W    = 24;
    localparam int D0_SUM_W    = 24;
    localparam int D0_MAX_W    = 15;
    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 80;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int DIV_W       = 24;
    localparam int DIV_STEP_W  = 5;

    localparam logic [13:0] PI_Q10     = 14'd3217;
    localparam logic [13:0] TWO_PI_Q10 = 14'd6434;
    localparam logic [15:0] FRAC_MAX   = 16'hFFFF;
    localparam logic [15:0] MEAN_POS_MAX = 16'h7FFF;
    localparam logic [15:0] MEAN_NEG_MIN = 16'h8000;

    localparam logic [DIV_STEP_W-1:0] FRAC_STEPS = 5'd16;
    localparam logic [DIV_STEP_W-1:0] MEAN_STEPS = 5'd24;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CONE_RADIUS_SQ   = 3'd0,
        REG_SIGNIFICANCE_CUT = 3'd1,
        REG_PROMPT_D0_CUT    = 3'd2,
        REG_MIN_TRACK_PT     = 3'd3,
        REG_JET_ETA_LIMIT    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [23:0] cone_radius_sq;
        logic [9:0]  significance_cut;
        logic [14:0] prompt_d0_cut;
        logic [15:0] min_track_pt;
        logic [12:0] jet_eta_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        cone_radius_sq:   24'd167772,
        significance_cut: 10'd48,
        prompt_d0_cut:    15'd200,
        min_track_pt:     16'd16,
        jet_eta_limit:    13'd2560
    };

    // Per-jet totals handed from the front to the back
    typedef struct packed {
        logic [PT_SUM_W-1:0]        sum_all_pt;
        logic [PT_SUM_W-1:0]        sum_sig_pt;
        logic [PT_SUM_W-1:0]        sum_prompt_pt;
        logic [D0_MAX_W-1:0]        max_d0;
        logic signed [D0_SUM_W-1:0] sum_d0;
        logic [CNT_W-1:0]           count;
        logic                       eta_ok;
    } jet_sum_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_W-1:0]      rem_init;
        logic [DIV_W-1:0]      num;
        logic [DIV_W-1:0]      divisor;
        logic [DIV_STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } div_rsp_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SIG_ISSUE,
        B_SIG_WAIT,
        B_PR_ISSUE,
        B_PR_WAIT,
        B_MEAN_ISSUE,
        B_MEAN_WAIT,
        B_OUT
    } back_state_t;

    function automatic logic [PT_SUM_W-1:0] sat_add_pt(logic [PT_SUM_W-1:0] acc,
                                                       logic [15:0] pt);
        logic [PT_SUM_W:0] s;
        s = {1'b0, acc} + {{(PT_SUM_W - 15){1'b0}}, pt};
        return s[PT_SUM_W] ? {PT_SUM_W{1'b1}} : s[PT_SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

[design/jet_track_displacement_tagger.sv]
`default_nettype none

// Channel   | Ports                         | Contents
// ----------+-------------------------------+---------------------------------------------
// tracks in | s_axis_tvalid/tready/tdata    | one track tested against one jet axis
//           | s_axis_tuser, s_axis_tlast    | tuser = track present, tlast = last of jet
// results   | m_axis_tvalid/tready/tdata    | one summary per jet, on the item with tlast
// config    | cfg_we, cfg_addr, cfg_wdata   | register write, no read-back
//
// One track is taken per cycle. Tracks pass three register stages (wrap and
// magnitudes, squares and error product, cone and significance compares) into the
// accumulators. A finished jet moves its totals into a two-entry queue; the back end
// runs them through one shared radix-2 divider (16 steps per fraction, 24 for the mean)
// and holds the summary in an output register. The input stalls only while a last
// item finds the queue full. Reset is synchronous, active low, and restores register
// defaults and empty totals.
module jet_track_displacement_tagger #(
    parameter int MAX_TRACKS  = jtdt_pkg::MAX_TRACKS_DEF,
    parameter int QUEUE_DEPTH = jtdt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // jet_eta[13:0], jet_phi[26:14], track_eta[40:27], track_phi[53:41],
    // pt[69:54], d0[85:70], d0 error[101:86], zero pad
    input  logic [jtdt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // track_present
    input  logic                             s_axis_tuser,
    input  logic                             s_axis_tlast,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // alpha_max[15:0], alpha_max_prompt[31:16], largest_d0[46:32], mean_d0[62:47],
    // track_count[71:63], good_jet[72], zero pad
    output logic [jtdt_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             cfg_we,
    input  logic [jtdt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [jtdt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import jtdt_pkg::*;

    cfg_t     cfg_reg;
    logic     q_push, q_full, q_valid, q_pop;
    jet_sum_t q_wdata, q_rdata;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Register file: the user must write only while the block is idle; the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_CONE_RADIUS_SQ:   cfg_reg.cone_radius_sq   <= cfg_wdata;
                REG_SIGNIFICANCE_CUT: cfg_reg.significance_cut <= cfg_wdata[9:0];
                REG_PROMPT_D0_CUT:    cfg_reg.prompt_d0_cut    <= cfg_wdata[14:0];
                REG_MIN_TRACK_PT:     cfg_reg.min_track_pt     <= cfg_wdata[15:0];
                REG_JET_ETA_LIMIT:    cfg_reg.jet_eta_limit    <= cfg_wdata[12:0];
                default: ; // drop writes to unused indexes
            endcase
        end
    end

    // Front: cone test and per-jet accumulation
    jtdt_front #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_present (s_axis_tuser),
        .in_last    (s_axis_tlast),
        .q_push     (q_push),
        .q_data     (q_wdata),
        .q_full     (q_full)
    );

    // Finished jets wait here for the divider
    jtdt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .valid   (q_valid),
        .rdata   (q_rdata),
        .pop     (q_pop)
    );

    // Back: fractions, mean and the output register
    jtdt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // Shared divider, one quotient bit per cycle
    jtdt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

endmodule

`default_nettype wire

[design/jtdt_front.sv]
`default_nettype none

module jtdt_front #(
    parameter int MAX_TRACKS = jtdt_pkg::MAX_TRACKS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  jtdt_pkg::cfg_t                  cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [jtdt_pkg::S_TDATA_W-1:0]  in_data,
    input  logic                            in_present,
    input  logic                            in_last,
    output logic                            q_push,
    output jtdt_pkg::jet_sum_t              q_data,
    input  logic                            q_full
);
    import jtdt_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LIMIT =
        CNT_W'((MAX_TRACKS > CNT_FIELD_MAX) ? CNT_FIELD_MAX : MAX_TRACKS);

    // unpack
    logic [13:0] jet_eta, track_eta;
    logic [12:0] jet_phi, track_phi;
    logic [15:0] trk_pt, trk_d0, track_err;

    assign jet_eta   = in_data[13:0];
    assign jet_phi   = in_data[26:14];
    assign track_eta = in_data[40:27];
    assign track_phi = in_data[53:41];
    assign trk_pt    = in_data[69:54];
    assign trk_d0    = in_data[85:70];
    assign track_err = in_data[101:86];

    // stage 1: differences, wrap, magnitudes
    logic [14:0] deta_s;
    logic [13:0] deta_abs;
    logic [13:0] dphi_s;
    logic [13:0] dphi_abs;
    logic [13:0] dphi_wrap;
    logic [15:0] ad0, aerr;
    logic [13:0] eta_abs;

    always_comb begin
        deta_s   = {jet_eta[13], jet_eta} - {track_eta[13], track_eta};
        deta_abs = deta_s[14] ? 14'(~deta_s + 15'd1) : deta_s[13:0];
        dphi_s   = {jet_phi[12], jet_phi} - {track_phi[12], track_phi};
        dphi_abs = dphi_s[13] ? (~dphi_s + 14'd1) : dphi_s;
        if (dphi_abs <= PI_Q10) begin
            dphi_wrap = dphi_abs;
        end else if (dphi_abs <= TWO_PI_Q10) begin
            dphi_wrap = TWO_PI_Q10 - dphi_abs;
        end else begin
            // wrapped difference went negative: square of its magnitude
            dphi_wrap = dphi_abs - TWO_PI_Q10;
        end
        ad0     = trk_d0[15] ? (~trk_d0 + 16'd1) : trk_d0;
        aerr    = track_err[15] ? (~track_err + 16'd1) : track_err;
        eta_abs = jet_eta[13] ? (~jet_eta + 14'd1) : jet_eta;
    end

    logic adv;

    logic        s1_valid_reg;
    logic [13:0] s1_deta_reg;
    logic [12:0] s1_dphi_reg;
    logic [15:0] s1_ad0_reg, s1_err_reg, s1_d0_reg, s1_pt_reg;
    logic        s1_present_reg, s1_last_reg, s1_eta_ok_reg, s1_pt_ok_reg, s1_prompt_ok_reg;

    logic        s2_valid_reg;
    logic [27:0] s2_deta2_reg;
    logic [25:0] s2_dphi2_reg;
    logic [25:0] s2_sig_rhs_reg;
    logic [15:0] s2_ad0_reg, s2_d0_reg, s2_pt_reg;
    logic        s2_present_reg, s2_last_reg, s2_eta_ok_reg, s2_pt_ok_reg, s2_prompt_ok_reg;

    logic        s3_valid_reg;
    logic        s3_take_reg, s3_sig_ok_reg, s3_prompt_ok_reg, s3_last_reg, s3_eta_ok_reg;
    logic [15:0] s3_d0_reg, s3_pt_reg;

    logic [28:0] dr2;
    logic        in_cone, sig_ok;

    assign dr2     = {1'b0, s2_deta2_reg} + {3'b000, s2_dphi2_reg};
    assign in_cone = dr2 < {5'b00000, cfg.cone_radius_sq};
    assign sig_ok  = {6'b000000, s2_ad0_reg, 4'b0000} < s2_sig_rhs_reg;

    // hold the whole pipe while a finished jet cannot enter the queue
    assign adv      = !(s3_valid_reg && s3_last_reg && q_full);
    assign in_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_deta_reg      <= deta_abs;
            s1_dphi_reg      <= dphi_wrap[12:0];
            s1_ad0_reg       <= ad0;
            s1_err_reg       <= aerr;
            s1_d0_reg        <= trk_d0;
            s1_pt_reg        <= trk_pt;
            s1_present_reg   <= in_present;
            s1_last_reg      <= in_last;
            s1_eta_ok_reg    <= eta_abs < {1'b0, cfg.jet_eta_limit};
            s1_pt_ok_reg     <= trk_pt > cfg.min_track_pt;
            s1_prompt_ok_reg <= ad0 < {1'b0, cfg.prompt_d0_cut};

            s2_deta2_reg     <= s1_deta_reg * s1_deta_reg;
            s2_dphi2_reg     <= s1_dphi_reg * s1_dphi_reg;
            s2_sig_rhs_reg   <= cfg.significance_cut * s1_err_reg;
            s2_ad0_reg       <= s1_ad0_reg;
            s2_d0_reg        <= s1_d0_reg;
            s2_pt_reg        <= s1_pt_reg;
            s2_present_reg   <= s1_present_reg;
            s2_last_reg      <= s1_last_reg;
            s2_eta_ok_reg    <= s1_eta_ok_reg;
            s2_pt_ok_reg     <= s1_pt_ok_reg;
            s2_prompt_ok_reg <= s1_prompt_ok_reg;

            s3_take_reg      <= s2_present_reg && in_cone && s2_pt_ok_reg;
            s3_sig_ok_reg    <= sig_ok;
            s3_prompt_ok_reg <= s2_prompt_ok_reg;
            s3_last_reg      <= s2_last_reg;
            s3_eta_ok_reg    <= s2_eta_ok_reg;
            s3_d0_reg        <= s2_d0_reg;
            s3_pt_reg        <= s2_pt_reg;
        end
    end

    // accumulators
    logic [PT_SUM_W-1:0]        sum_all_reg, sum_sig_reg, sum_prompt_reg;
    logic [PT_SUM_W-1:0]        sum_all_next, sum_sig_next, sum_prompt_next;
    logic [D0_MAX_W-1:0]        max_d0_reg, max_d0_next;
    logic signed [D0_SUM_W-1:0] sum_d0_reg, sum_d0_next;
    logic [CNT_W-1:0]           count_reg, count_next;

    logic                       take;
    logic signed [D0_SUM_W:0]   d0_wide;
    jet_sum_t                   upd;

    always_comb begin
        take    = s3_valid_reg && s3_take_reg && (count_reg < CNT_LIMIT);
        d0_wide = (D0_SUM_W + 1)'(sum_d0_reg) + (D0_SUM_W + 1)'($signed(s3_d0_reg));

        upd            = '0;
        upd.sum_all_pt = sum_all_reg;
        upd.sum_sig_pt = sum_sig_reg;
        upd.sum_prompt_pt = sum_prompt_reg;
        upd.max_d0     = max_d0_reg;
        upd.sum_d0     = sum_d0_reg;
        upd.count      = count_reg;
        upd.eta_ok     = s3_eta_ok_reg;

        if (take) begin
            upd.count      = count_reg + 1'b1;
            upd.sum_all_pt = sat_add_pt(sum_all_reg, s3_pt_reg);
            if (s3_sig_ok_reg) begin
                upd.sum_sig_pt = sat_add_pt(sum_sig_reg, s3_pt_reg);
            end
            if (s3_prompt_ok_reg) begin
                upd.sum_prompt_pt = sat_add_pt(sum_prompt_reg, s3_pt_reg);
            end
            if (!s3_d0_reg[15] && (s3_d0_reg[14:0] > max_d0_reg)) begin
                upd.max_d0 = s3_d0_reg[14:0];
            end
            if (d0_wide[D0_SUM_W] != d0_wide[D0_SUM_W-1]) begin
                // saturate to the signed range
                upd.sum_d0 = d0_wide[D0_SUM_W] ? {1'b1, {(D0_SUM_W - 1){1'b0}}}
                                               : {1'b0, {(D0_SUM_W - 1){1'b1}}};
            end else begin
                upd.sum_d0 = d0_wide[D0_SUM_W-1:0];
            end
        end

        // a finished jet clears everything
        if (s3_last_reg) begin
            sum_all_next    = '0;
            sum_sig_next    = '0;
            sum_prompt_next = '0;
            max_d0_next     = '0;
            sum_d0_next     = '0;
            count_next      = '0;
        end else begin
            sum_all_next    = upd.sum_all_pt;
            sum_sig_next    = upd.sum_sig_pt;
            sum_prompt_next = upd.sum_prompt_pt;
            max_d0_next     = upd.max_d0;
            sum_d0_next     = upd.sum_d0;
            count_next      = upd.count;
        end
    end

    assign q_push = s3_valid_reg && s3_last_reg && !q_full;
    assign q_data = upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_all_reg    <= '0;
            sum_sig_reg    <= '0;
            sum_prompt_reg <= '0;
            max_d0_reg     <= '0;
            sum_d0_reg     <= '0;
            count_reg      <= '0;
        end else if (s3_valid_reg && adv) begin
            sum_all_reg    <= sum_all_next;
            sum_sig_reg    <= sum_sig_next;
            sum_prompt_reg <= sum_prompt_next;
            max_d0_reg     <= max_d0_next;
            sum_d0_reg     <= sum_d0_next;
            count_reg      <= count_next;
        end
    end

endmodule

`default_nettype wire

[design/jtdt_queue.sv]
`default_nettype none

module jtdt_queue #(
    parameter int DEPTH = jtdt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  jtdt_pkg::jet_sum_t wdata,
    output logic               full,
    output logic               valid,
    output jtdt_pkg::jet_sum_t rdata,
    input  logic               pop
);
    import jtdt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

    jet_sum_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0]   fill_reg;
    logic                do_push, do_pop;

    assign full    = fill_reg == FULL_CNT;
    assign valid   = fill_reg != '0;
    assign rdata   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

[design/jtdt_div.sv]
`default_nettype none

module jtdt_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  jtdt_pkg::div_req_t req,
    output jtdt_pkg::div_rsp_t rsp
);
    import jtdt_pkg::*;

    logic                  busy_reg, done_reg;
    logic [DIV_STEP_W-1:0] cnt_reg;
    logic [DIV_W-1:0]      rem_reg, num_reg, div_reg, quo_reg;

    logic [DIV_W:0]        trial, diff;
    logic                  fits;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    always_comb begin
        trial = {rem_reg, num_reg[DIV_W-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = trial >= {1'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.rem_init;
            num_reg <= req.num;
            div_reg <= req.divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            num_reg <= {num_reg[DIV_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

[design/jtdt_back.sv]
`default_nettype none

module jtdt_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  jtdt_pkg::jet_sum_t              q_data,
    output logic                            q_pop,
    output jtdt_pkg::div_req_t              div_req,
    input  jtdt_pkg::div_rsp_t              div_rsp,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [jtdt_pkg::M_TDATA_W-1:0]  out_data
);
    import jtdt_pkg::*;

    back_state_t state_reg, state_next;
    jet_sum_t    ent_reg, ent_next;
    logic [15:0] alpha_reg, alpha_next;
    logic [15:0] prompt_reg, prompt_next;
    logic [15:0] mean_reg, mean_next;
    logic        m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic              d0_neg;
    logic [DIV_W-1:0]  d0_mag;
    logic              good;

    assign d0_neg = ent_reg.sum_d0[D0_SUM_W-1];
    assign d0_mag = d0_neg ? DIV_W'(~ent_reg.sum_d0 + 1'b1) : DIV_W'(ent_reg.sum_d0);
    assign good   = ent_reg.eta_ok && (ent_reg.count != '0);

    always_comb begin
        state_next   = state_reg;
        ent_next     = ent_reg;
        alpha_next   = alpha_reg;
        prompt_next  = prompt_reg;
        mean_next    = mean_reg;
        m_valid_next = m_valid_reg && !out_ready;
        m_data_next  = m_data_reg;
        q_pop        = 1'b0;
        div_req      = '0;

        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    ent_next   = q_data;
                    state_next = B_SIG_ISSUE;
                end
            end
            B_SIG_ISSUE: begin
                if (ent_reg.sum_all_pt == '0 || ent_reg.sum_sig_pt >= ent_reg.sum_all_pt) begin
                    alpha_next = FRAC_MAX;
                    state_next = B_PR_ISSUE;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = ent_reg.sum_sig_pt;
                    div_req.divisor  = ent_reg.sum_all_pt;
                    div_req.steps    = FRAC_STEPS;
                    state_next       = B_SIG_WAIT;
                end
            end
            B_SIG_WAIT: begin
                if (div_rsp.done) begin
                    alpha_next = div_rsp.quo[15:0];
                    state_next = B_PR_ISSUE;
                end
            end
            B_PR_ISSUE: begin
                if (ent_reg.sum_all_pt == '0 ||
                    ent_reg.sum_prompt_pt >= ent_reg.sum_all_pt) begin
                    prompt_next = FRAC_MAX;
                    state_next  = B_MEAN_ISSUE;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = ent_reg.sum_prompt_pt;
                    div_req.divisor  = ent_reg.sum_all_pt;
                    div_req.steps    = FRAC_STEPS;
                    state_next       = B_PR_WAIT;
                end
            end
            B_PR_WAIT: begin
                if (div_rsp.done) begin
                    prompt_next = div_rsp.quo[15:0];
                    state_next  = B_MEAN_ISSUE;
                end
            end
            B_MEAN_ISSUE: begin
                if (ent_reg.count == '0) begin
                    mean_next  = '0;
                    state_next = B_OUT;
                end else begin
                    div_req.start   = 1'b1;
                    div_req.num     = d0_mag;
                    div_req.divisor = DIV_W'(ent_reg.count);
                    div_req.steps   = MEAN_STEPS;
                    state_next      = B_MEAN_WAIT;
                end
            end
            B_MEAN_WAIT: begin
                if (div_rsp.done) begin
                    if (d0_neg) begin
                        mean_next = (div_rsp.quo > DIV_W'(MEAN_NEG_MIN)) ? MEAN_NEG_MIN
                                  : (~div_rsp.quo[15:0] + 16'd1);
                    end else begin
                        mean_next = (div_rsp.quo > DIV_W'(MEAN_POS_MAX)) ? MEAN_POS_MAX
                                  : div_rsp.quo[15:0];
                    end
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                if (!m_valid_reg || out_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'b0000000, good, ent_reg.count, mean_reg,
                                    ent_reg.max_d0, prompt_reg, alpha_reg};
                    state_next   = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg    <= ent_next;
        alpha_reg  <= alpha_next;
        prompt_reg <= prompt_next;
        mean_reg   <= mean_next;
        m_data_reg <= m_data_next;
    end

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;

endmodule

`default_nettype wire

[design/jtdt_checker.sv]
`default_nettype none

module jtdt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // good jet needs at least one counted track
    a_good_needs_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[72] |-> m_axis_tdata[71:63] != 9'd0)
        else $error("good jet flagged with no tracks");

    // a jet with no counted tracks has no pT and no d0
    a_empty_jet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[71:63] == 9'd0) |->
            (m_axis_tdata[15:0] == 16'hFFFF) && (m_axis_tdata[31:16] == 16'hFFFF) &&
            (m_axis_tdata[46:32] == 15'd0) && (m_axis_tdata[62:47] == 16'd0))
        else $error("empty jet summary inconsistent");

endmodule

bind jet_track_displacement_tagger jtdt_checker u_jtdt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[tb/jet_track_displacement_tagger_test.sv]
`default_nettype none

// Stimulus runs in three idling phases:
// - sender gaps light and receiver stalls heavy
// - the reverse
// - no idling at all
// Each accepted track is folded into a software copy of the jet accumulators. On the
// item that closes a jet the expected summary is queued. A monitor on the result
// channel pops and compares every summary field by field.
module jet_track_displacement_tagger_test;
    import jtdt_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 11;
    localparam int CFG_SETTLE   = 80;     // covers the track pipeline plus one back-end pass
    localparam int END_SETTLE   = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int RUN_LIMIT    = 8_000_000;
    localparam int TRACK_LIMIT  = (MAX_TRACKS_DEF > CNT_FIELD_MAX) ? CNT_FIELD_MAX
                                                                   : MAX_TRACKS_DEF;
    localparam longint SIG_SCALE   = 16;  // significance cut is in 1/16 units
    localparam longint PT_SUM_TOP  = 16777215;
    localparam longint D0_SUM_HI   = 8388607;
    localparam longint D0_SUM_LO   = -8388608;
    localparam longint MEAN_HI     = 32767;
    localparam longint MEAN_LO     = -32768;

    typedef struct {
        logic signed [13:0] jet_eta;
        logic signed [12:0] jet_phi;
        logic signed [13:0] track_eta;
        logic signed [12:0] track_phi;
        logic [15:0]        trk_pt;
        logic signed [15:0] trk_d0;
        logic signed [15:0] trk_d0_err;
        logic               present;
        logic               last;
    } track_item_t;

    typedef struct {
        logic [15:0]        alpha_max;
        logic [15:0]        alpha_max_prompt;
        logic [14:0]        largest_d0;
        logic signed [15:0] mean_d0;
        logic [8:0]         track_count;
        logic               good_jet;
    } jet_summary_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_we        = 1'b0;
    cfg_reg_t              cfg_addr      = REG_CONE_RADIUS_SQ;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    // Idling percentages of the current phase
    int sender_idle_pct    = 34;
    int receiver_stall_pct = 85;

    // Receiver hold-off: toggle hold_kick to start one long stall
    logic hold_kick = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    // Shadow of the register file and the per-jet accumulators
    cfg_t        cur_cfg = CFG_RESET;
    logic [23:0] acc_all_pt    = '0;
    logic [23:0] acc_sig_pt    = '0;
    logic [23:0] acc_prompt_pt = '0;
    logic [14:0] acc_max_d0    = '0;
    longint      acc_sum_d0    = 0;
    int          acc_count     = 0;

    jet_summary_t expected_summaries[$];

    int tracks_sent        = 0;
    int jets_closed        = 0;
    int summaries_checked  = 0;
    int cfg_settings       = 0;
    int mismatches         = 0;

    jet_track_displacement_tagger u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    function automatic logic [31:0] rnd(input int bits);
        return $urandom & ((32'h1 << bits) - 1);
    endfunction

    function automatic int clamp_int(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic track_item_t mk_track(input int jeta, input int jphi, input int teta,
                                             input int tphi, input int pt, input int d0,
                                             input int err, input bit present,
                                             input bit last);
        track_item_t t;
        t.jet_eta    = 14'(jeta);
        t.jet_phi    = 13'(jphi);
        t.track_eta  = 14'(teta);
        t.track_phi  = 13'(tphi);
        t.trk_pt     = 16'(pt);
        t.trk_d0     = 16'(d0);
        t.trk_d0_err = 16'(err);
        t.present    = present;
        t.last       = last;
        return t;
    endfunction

    // Pack fields from the lowest bit up, pad with zeros
    function automatic logic [S_TDATA_W-1:0] pack_track(input track_item_t t);
        logic [S_TDATA_W-1:0] d;
        d         = '0;
        d[13:0]   = t.jet_eta;
        d[26:14]  = t.jet_phi;
        d[40:27]  = t.track_eta;
        d[53:41]  = t.track_phi;
        d[69:54]  = t.trk_pt;
        d[85:70]  = t.trk_d0;
        d[101:86] = t.trk_d0_err;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Expected behaviour
    // ------------------------------------------------------------------

    function automatic logic [23:0] pt_sum_add(input logic [23:0] acc, input logic [15:0] pt);
        longint s;
        s = longint'(acc) + longint'(pt);
        return (s > PT_SUM_TOP) ? 24'(PT_SUM_TOP) : s[23:0];
    endfunction

    // Q0.16 share of part in whole; saturate, and report full scale for an empty jet
    function automatic logic [15:0] q16_share(input logic [23:0] part, input logic [23:0] whole);
        longint q;
        if (whole == 0) return FRAC_MAX;
        q = (longint'(part) << 16) / longint'(whole);
        return (q > longint'(FRAC_MAX)) ? FRAC_MAX : q[15:0];
    endfunction

    // Fold one accepted track into the jet totals; close the jet on its last item
    function automatic void tally_track(input track_item_t t);
        longint       deta;
        longint       dphi;
        longint       dr2;
        longint       ad0;
        longint       err;
        longint       s;
        longint       mean;
        longint       jeta_abs;
        jet_summary_t r;

        if (t.present && acc_count < TRACK_LIMIT) begin
            deta = longint'(t.jet_eta) - longint'(t.track_eta);
            if (deta < 0) deta = -deta;
            dphi = longint'(t.jet_phi) - longint'(t.track_phi);
            if (dphi < 0) dphi = -dphi;
            // one wrap only; a negative result is squared as it stands
            if (dphi > longint'(PI_Q10)) dphi = longint'(TWO_PI_Q10) - dphi;
            dr2 = deta * deta + dphi * dphi;
            if (dr2 < longint'(cur_cfg.cone_radius_sq) &&
                t.trk_pt > cur_cfg.min_track_pt) begin
                ad0 = longint'(t.trk_d0);
                if (ad0 < 0) ad0 = -ad0;
                err = longint'(t.trk_d0_err);
                if (err < 0) err = -err;
                acc_count++;
                if (longint'(t.trk_d0) > longint'(acc_max_d0))
                    acc_max_d0 = t.trk_d0[14:0];
                s = acc_sum_d0 + longint'(t.trk_d0);
                if (s > D0_SUM_HI) s = D0_SUM_HI;
                if (s < D0_SUM_LO) s = D0_SUM_LO;
                acc_sum_d0 = s;
                acc_all_pt = pt_sum_add(acc_all_pt, t.trk_pt);
                if (err != 0 && ad0 * SIG_SCALE < longint'(cur_cfg.significance_cut) * err)
                    acc_sig_pt = pt_sum_add(acc_sig_pt, t.trk_pt);
                if (ad0 < longint'(cur_cfg.prompt_d0_cut))
                    acc_prompt_pt = pt_sum_add(acc_prompt_pt, t.trk_pt);
            end
        end

        if (t.last) begin
            mean = 0;
            if (acc_count != 0) mean = acc_sum_d0 / longint'(acc_count);
            if (mean > MEAN_HI) mean = MEAN_HI;
            if (mean < MEAN_LO) mean = MEAN_LO;
            jeta_abs = longint'(t.jet_eta);
            if (jeta_abs < 0) jeta_abs = -jeta_abs;
            r.alpha_max        = q16_share(acc_sig_pt, acc_all_pt);
            r.alpha_max_prompt = q16_share(acc_prompt_pt, acc_all_pt);
            r.largest_d0       = acc_max_d0;
            r.mean_d0          = mean[15:0];
            r.track_count      = acc_count[8:0];
            r.good_jet         = (jeta_abs < longint'(cur_cfg.jet_eta_limit)) &&
                                 (acc_count != 0);
            expected_summaries.insert(expected_summaries.size(), r);
            jets_closed++;
            acc_all_pt    = '0;
            acc_sig_pt    = '0;
            acc_prompt_pt = '0;
            acc_max_d0    = '0;
            acc_sum_d0    = 0;
            acc_count     = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall at random or hold off, and compare each summary
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (hold_kick != hold_seen) begin
            hold_seen     <= hold_kick;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_summary(input logic [M_TDATA_W-1:0] d);
        jet_summary_t want;
        if (expected_summaries.size() == 0) begin
            $error("jet summary arrived with none outstanding");
            mismatches++;
        end else begin
            want = expected_summaries.pop_front();
            compare_field("alpha_max",        want.alpha_max,         d[15:0]);
            compare_field("alpha_max_prompt", want.alpha_max_prompt,  d[31:16]);
            compare_field("largest_d0",       want.largest_d0,        d[46:32]);
            compare_field("mean_d0",          $signed(want.mean_d0),  $signed(d[62:47]));
            compare_field("track_count",      want.track_count,       d[71:63]);
            compare_field("good_jet",         want.good_jet,          d[72]);
            summaries_checked++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) check_summary(m_axis_tdata);
    end

    // ------------------------------------------------------------------
    // Track side
    // ------------------------------------------------------------------

    // Offer one item, idling first at the phase rate; fold it in once taken
    task automatic send_track(input track_item_t t);
        while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tdata  <= pack_track(t);
        s_axis_tuser  <= t.present;
        s_axis_tlast  <= t.last;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        tally_track(t);
        tracks_sent++;
    endtask

    // Drop valid and hold until every summary has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_summaries.size() != 0) @(posedge aclk);
    endtask

    task automatic put_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_CONE_RADIUS_SQ:   cur_cfg.cone_radius_sq   = val[23:0];
            REG_SIGNIFICANCE_CUT: cur_cfg.significance_cut = val[9:0];
            REG_PROMPT_D0_CUT:    cur_cfg.prompt_d0_cut    = val[14:0];
            REG_MIN_TRACK_PT:     cur_cfg.min_track_pt     = val[15:0];
            REG_JET_ETA_LIMIT:    cur_cfg.jet_eta_limit    = val[12:0];
            default: ;
        endcase
    endtask

    // Rewrite the whole register file once the block has gone quiet
    task automatic write_registers(input logic [23:0] cone, input logic [9:0] sig_cut,
                                   input logic [14:0] prompt_cut, input logic [15:0] min_pt,
                                   input logic [12:0] eta_lim);
        drain_results();
        repeat (CFG_SETTLE) @(posedge aclk);
        put_register(REG_CONE_RADIUS_SQ,   CFG_DATA_W'(cone));
        put_register(REG_SIGNIFICANCE_CUT, CFG_DATA_W'(sig_cut));
        put_register(REG_PROMPT_D0_CUT,    CFG_DATA_W'(prompt_cut));
        put_register(REG_MIN_TRACK_PT,     CFG_DATA_W'(min_pt));
        put_register(REG_JET_ETA_LIMIT,    CFG_DATA_W'(eta_lim));
        cfg_we <= 1'b0;
        cfg_settings++;
    endtask

    // A track scattered around the jet axis; phi is folded back across pi
    // so that wrapped pairs turn up often
    function automatic track_item_t near_track(input logic signed [13:0] axis_eta,
                                               input logic signed [12:0] axis_phi);
        track_item_t t;
        int          e;
        int          p;
        t.jet_eta = axis_eta;
        t.jet_phi = axis_phi;
        e = int'(axis_eta) + int'($urandom_range(0, 800)) - 400;
        p = int'(axis_phi) + int'($urandom_range(0, 800)) - 400;
        if (p > int'(PI_Q10)) p = p - int'(TWO_PI_Q10);
        if (p < -int'(PI_Q10)) p = p + int'(TWO_PI_Q10);
        t.track_eta = 14'(clamp_int(e, -8192, 8191));
        t.track_phi = 13'(clamp_int(p, -4096, 4095));
        t.trk_pt    = ($urandom_range(0, 3) == 0) ? 16'(rnd(16))
                                                  : 16'($urandom_range(0, 1500));
        t.trk_d0    = ($urandom_range(0, 1) == 0) ? 16'(rnd(16))
                                                  : 16'(int'($urandom_range(0, 1200)) - 600);
        case ($urandom_range(0, 9))
            0:       t.trk_d0_err = '0;
            1, 2, 3: t.trk_d0_err = 16'(rnd(16));
            default: t.trk_d0_err = 16'(int'($urandom_range(0, 400)) - 200);
        endcase
        t.present = ($urandom_range(0, 99) < 92);
        t.last    = 1'b0;
        return t;
    endfunction

    function automatic track_item_t noise_track();
        track_item_t t;
        t.jet_eta    = 14'(rnd(14));
        t.jet_phi    = 13'(rnd(13));
        t.track_eta  = 14'(rnd(14));
        t.track_phi  = 13'(rnd(13));
        t.trk_pt     = 16'(rnd(16));
        t.trk_d0     = 16'(rnd(16));
        t.trk_d0_err = 16'(rnd(16));
        t.present    = 1'(rnd(1));
        t.last       = ($urandom_range(0, 3) == 0);
        return t;
    endfunction

    // Mostly well-formed jets around one axis; the rest is unrelated noise
    task automatic send_random_jet(input int max_len);
        track_item_t        t;
        int                 len;
        bit                 noisy;
        logic signed [13:0] axis_eta;
        logic signed [12:0] axis_phi;
        len      = $urandom_range(1, max_len);
        noisy    = ($urandom_range(0, 99) < 20);
        axis_eta = ($urandom_range(0, 1) == 0) ? 14'(rnd(14))
                                               : 14'(int'($urandom_range(0, 6000)) - 3000);
        axis_phi = 13'(rnd(13));
        for (int i = 0; i < len; i++) begin
            t      = noisy ? noise_track() : near_track(axis_eta, axis_phi);
            t.last = t.last || (i == len - 1);
            send_track(t);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_cases();
        // cone boundary: a squared distance equal to the cone is outside
        write_registers(24'd10000, CFG_RESET.significance_cut, CFG_RESET.prompt_d0_cut,
                        CFG_RESET.min_track_pt, CFG_RESET.jet_eta_limit);
        send_track(mk_track(0, 0, 100, 0, 500, 10, 50, 1, 0));
        send_track(mk_track(0, 0, 99, 0, 500, 10, 50, 1, 0));
        send_track(mk_track(0, 0, 60, 80, 500, 10, 50, 1, 1));
        write_registers(CFG_RESET.cone_radius_sq, CFG_RESET.significance_cut,
                        CFG_RESET.prompt_d0_cut, CFG_RESET.min_track_pt,
                        CFG_RESET.jet_eta_limit);
        // empty jet: no tracks at all
        send_track(mk_track(0, 0, 0, 0, 0, 0, 0, 0, 1));
        // field extremes, zero error, pT at the minimum, far-apart axes beyond pi
        send_track(mk_track(0, 0, 0, 0, 65535, 32767, 0, 1, 0));
        send_track(mk_track(0, 0, 0, 0, 16, 5, 5, 1, 0));
        send_track(mk_track(0, 0, 0, 0, 17, -32768, -32768, 1, 0));
        send_track(mk_track(-8192, -4096, 8191, 4095, 65535, -1, 1, 1, 0));
        send_track(mk_track(8191, 4095, 8191, 4095, 100, -7, 0, 1, 1));
        // phi wrap across pi, prompt and significance boundaries, good jet
        send_track(mk_track(2559, 3200, 2559, -3200, 1000, 199, 1, 1, 0));
        send_track(mk_track(2559, 3200, 2600, -3210, 1000, 200, 67, 1, 0));
        send_track(mk_track(2559, -3217, 2559, 3217, 1000, 48, 16, 1, 0));
        send_track(mk_track(2559, 0, 2559, 0, 1000, 47, 16, 1, 1));
        // jet eta on the limit, negative d0 only, mean truncated toward zero
        send_track(mk_track(-2560, 0, -2560, 0, 500, -3, 0, 1, 0));
        send_track(mk_track(-2560, 0, -2560, 0, 500, -4, 0, 1, 1));
        // empty item inside a jet adds nothing
        send_track(mk_track(0, 0, 0, 0, 800, 100, 100, 0, 0));
        send_track(mk_track(0, 0, 0, 0, 800, 100, 100, 1, 1));
        drain_results();
    endtask

    // More tracks in the cone than the counter takes
    task automatic test_track_cap();
        track_item_t        t;
        logic signed [13:0] axis_eta;
        logic signed [12:0] axis_phi;
        axis_eta = 14'(int'($urandom_range(0, 4000)) - 2000);
        axis_phi = 13'(rnd(13));
        for (int i = 0; i < TRACK_LIMIT + 6; i++) begin
            t = mk_track(axis_eta, axis_phi, axis_eta, axis_phi,
                         int'($urandom_range(17, 65535)), int'(rnd(16)), int'(rnd(16)), 1,
                         i == TRACK_LIMIT + 5);
            send_track(t);
        end
        drain_results();
    endtask

    task automatic test_random_jets(input int n_tracks);
        int target;
        target = tracks_sent + n_tracks;
        while (tracks_sent < target) send_random_jet(6);
        drain_results();
    endtask

    // Register extremes and random settings, a few jets under each
    task automatic test_register_sweep();
        for (int k = 0; k < 7; k++) begin
            case (k)
                0: write_registers('0, '0, '0, '0, '0);
                1: write_registers('1, '1, '1, '0, '1);
                2: write_registers('1, '1, '1, '1, '1);
                3, 4, 5: write_registers(24'(rnd(24) >> $urandom_range(0, 8)), 10'(rnd(10)),
                                         15'(rnd(15)), 16'($urandom_range(0, 64)),
                                         13'(rnd(13)));
                default: write_registers(CFG_RESET.cone_radius_sq, CFG_RESET.significance_cut,
                                         CFG_RESET.prompt_d0_cut, CFG_RESET.min_track_pt,
                                         CFG_RESET.jet_eta_limit);
            endcase
            repeat (3) send_random_jet(4);
        end
        drain_results();
    endtask

    // Stall the result side long enough for the jet queue to fill and back up
    // the track input, then pause the sender until everything has drained
    task automatic test_output_holdoff();
        logic signed [13:0] axis_eta;
        logic signed [12:0] axis_phi;
        track_item_t        t;
        hold_kick <= ~hold_kick;
        repeat (30) begin
            axis_eta = 14'(rnd(14));
            axis_phi = 13'(rnd(13));
            t        = near_track(axis_eta, axis_phi);
            t.last   = 1'b1;
            send_track(t);
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        sender_idle_pct    = 34;
        receiver_stall_pct = 85;
        test_directed_cases();
        test_track_cap();
        test_random_jets(20);

        sender_idle_pct    = 85;
        receiver_stall_pct = 34;
        test_register_sweep();
        test_random_jets(20);

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        test_output_holdoff();
        test_random_jets(20);

        drain_results();
        repeat (END_SETTLE) @(posedge aclk);

        $display("Covered %0d tracks in %0d jets over %0d register settings,", tracks_sent,
                 jets_closed, cfg_settings);
        $display("incl. track cap, phi wrap and output hold-off; %0d summaries, %0d errors",
                 summaries_checked, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard stop in case the block hangs
    initial begin
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
design/jtdt_pkg.sv
design/jtdt_front.sv
design/jtdt_queue.sv
design/jtdt_div.sv
design/jtdt_back.sv
design/jet_track_displacement_tagger.sv
design/jtdt_checker.sv
tb/jet_track_displacement_tagger_test.sv
